/* rtl/hashed_entry_table_with_replacement_macros.svh */
`ifndef HASHED_ENTRY_TABLE_WITH_REPLACEMENT_MACROS_SVH
`define HASHED_ENTRY_TABLE_WITH_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HETR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define HETR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/het_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package het_pkg;

  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  localparam logic [1:0] BOUND_ABSENT = 2'd0;
  localparam logic [1:0] BOUND_BOTH   = 2'd3;

  localparam logic [1:0] REG_SEARCH_GENERATION = 2'd0;
  localparam logic [1:0] REG_MATE_THRESHOLD    = 2'd1;

  localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd31744;

  localparam int PERMILLE_SCALE = 1000;
  localparam int PERMILLE_W     = 10;

  localparam logic signed [10:0] DEPTH_MAX    = 11'sd127;
  localparam logic signed [10:0] DEPTH_MIN    = -11'sd128;
  localparam logic signed [11:0] EXACT_BONUS  = 12'sd2;
  localparam logic signed [17:0] SCORE_MAX    = 18'sd32767;
  localparam logic signed [17:0] SCORE_MIN    = -18'sd32768;

  typedef struct packed {
    logic [5:0]  gen;
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] eval;
    logic [15:0] score;
    logic [15:0] move;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/hashed_entry_table_with_replacement.sv */
// Probe, store and unused mode: accept and slot read in the idle state, then update and
// result in the execute state, which holds while the output is stalled; no new item is
// accepted until that result is loaded. Fill estimate: a walk over the first SAMPLE slots,
// SAMPLE the smaller of FILL_SAMPLE and 2^INDEX_BITS, then a reciprocal multiply for the
// per-mille scaling. Reset: synchronous; a clearing pass writes every slot to zero, during
// which no item is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_entry_table_with_replacement_macros.svh"

module hashed_entry_table_with_replacement
  import het_pkg::*;
#(
  parameter int INDEX_BITS  = 16,
  parameter int FILL_SAMPLE = 1000
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // position_key[63:0], new_score[79:64], new_eval[95:80], new_depth[106:96],
  // new_bound[108:107], new_move[124:109], ply_from_root[132:125], zero pad[135:133]
  input  wire logic [135:0] s_tdata,
  // mode[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit[0], found_move[16:1], found_score[32:17], found_eval[48:33], found_depth[56:49],
  // found_bound[58:57], fill_permille[68:59], zero pad[71:69]
  output logic [71:0]       m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [14:0]  cfg_data
);

  localparam int SLOTS       = 2 ** INDEX_BITS;
  localparam int SAMPLE      = (SLOTS < FILL_SAMPLE) ? SLOTS : FILL_SAMPLE;
  localparam int SAMPLE_W    = $clog2(SAMPLE + 1);
  localparam int NUM_W       = SAMPLE_W + PERMILLE_W;
  localparam int RECIP_SHIFT = NUM_W + $clog2(SAMPLE);
  localparam int RECIP_W     = NUM_W + 2;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLE) - 64'd1) / 64'(SAMPLE));

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FDONE = 3'd5;

  logic [2:0]            state;
  logic [INDEX_BITS-1:0] clr_addr;
  logic [5:0]            gen_reg;
  logic [14:0]           thr_reg;

  logic [1:0]         mode_q;
  logic [63:0]        key_q;
  logic signed [15:0] score_q;
  logic [15:0]        eval_q;
  logic signed [10:0] depth_q;
  logic [1:0]         bound_q;
  logic [15:0]        move_q;
  logic [7:0]         ply_q;

  logic [127:0]          mem [SLOTS];
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [127:0]          mem_wdata;
  logic                  mem_re;
  logic [INDEX_BITS-1:0] mem_raddr;
  logic [127:0]          mem_rdata;

  logic [SAMPLE_W-1:0]  fill_cnt;
  logic                 fill_pend;
  logic [SAMPLE_W-1:0]  fill_used;
  logic [NUM_W-1:0]     div_num;
  logic [PROD_W-1:0]    div_prod;

  logic               in_xfer;
  logic               out_free;
  logic               load_out;
  logic [71:0]        res_data;
  entry_t             cur;
  entry_t             new_entry;
  logic               cur_nz;
  logic               key_eq;
  logic               probe_hit;
  logic               same;
  logic               replace;
  logic               fill_count_en;
  logic signed [11:0] depth_cmp;
  logic signed [11:0] cur_depth_ext;
  logic signed [17:0] score_ext;
  logic signed [17:0] thr_ext;
  logic signed [17:0] ply_ext;
  logic signed [17:0] score_adj;
  logic [15:0]        score_sat;
  logic [7:0]         depth_clamp;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = ((state == ST_EXEC) || (state == ST_FDONE)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_reg <= '0;
      thr_reg <= MATE_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEARCH_GENERATION: gen_reg <= cfg_data[5:0];
        REG_MATE_THRESHOLD:    thr_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    cur           = entry_t'(mem_rdata[63:0]);
    cur_nz        = |mem_rdata[63:0];
    key_eq        = (mem_rdata[127:64] == key_q);
    probe_hit     = key_eq && cur_nz && (cur.bound != BOUND_ABSENT);
    same          = cur_nz && key_eq;
    depth_cmp     = {depth_q[10], depth_q} + ((bound_q == BOUND_BOTH) ? EXACT_BONUS : 12'sd0);
    cur_depth_ext = {{4{cur.depth[7]}}, cur.depth};
    replace       = !cur_nz || (cur.bound == BOUND_ABSENT) || same || (cur.gen != gen_reg) ||
                    (depth_cmp >= cur_depth_ext);

    score_ext = {{2{score_q[15]}}, score_q};
    thr_ext   = {3'b000, thr_reg};
    ply_ext   = {10'd0, ply_q};
    priority if (score_ext >= thr_ext) begin
      score_adj = score_ext + ply_ext;
    end else if (score_ext <= -thr_ext) begin
      score_adj = score_ext - ply_ext;
    end else begin
      score_adj = score_ext;
    end
    priority if (score_adj > SCORE_MAX) begin
      score_sat = 16'h7FFF;
    end else if (score_adj < SCORE_MIN) begin
      score_sat = 16'h8000;
    end else begin
      score_sat = score_adj[15:0];
    end

    priority if (depth_q > DEPTH_MAX) begin
      depth_clamp = DEPTH_MAX[7:0];
    end else if (depth_q < DEPTH_MIN) begin
      depth_clamp = DEPTH_MIN[7:0];
    end else begin
      depth_clamp = depth_q[7:0];
    end

    new_entry.gen   = gen_reg;
    new_entry.bound = bound_q;
    new_entry.depth = depth_clamp;
    new_entry.eval  = eval_q;
    new_entry.score = score_sat;
    new_entry.move  = (same && (move_q == 16'd0)) ? cur.move : move_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = key_q[INDEX_BITS-1:0];
    mem_wdata = {key_q, new_entry};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if ((state == ST_EXEC) && out_free && (mode_q == MODE_STORE) && replace) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = s_tdata[INDEX_BITS-1:0];
    if (in_xfer) begin
      mem_re = 1'b1;
    end else if ((state == ST_FILL) && (fill_cnt < SAMPLE_W'(SAMPLE))) begin
      mem_re    = 1'b1;
      mem_raddr = INDEX_BITS'(fill_cnt);
    end
  end

  assign fill_count_en = fill_pend && cur_nz && (cur.gen == gen_reg);

  always_comb begin
    res_data = '0;
    if (state == ST_FDONE) begin
      res_data[68:59] = div_prod[RECIP_SHIFT +: PERMILLE_W];
    end else if ((mode_q == MODE_PROBE) && probe_hit) begin
      res_data[0]     = 1'b1;
      res_data[16:1]  = cur.move;
      res_data[32:17] = cur.score;
      res_data[48:33] = cur.eval;
      res_data[56:49] = cur.depth;
      res_data[58:57] = cur.bound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == INDEX_BITS'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state <= (s_tuser == MODE_FILL) ? ST_FILL : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_FILL: begin
          if ((fill_cnt == SAMPLE_W'(SAMPLE)) && !fill_pend) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          state <= ST_FDONE;
        end
        ST_FDONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_q    <= s_tuser;
      key_q     <= s_tdata[63:0];
      score_q   <= s_tdata[79:64];
      eval_q    <= s_tdata[95:80];
      depth_q   <= s_tdata[106:96];
      bound_q   <= s_tdata[108:107];
      move_q    <= s_tdata[124:109];
      ply_q     <= s_tdata[132:125];
      fill_cnt  <= '0;
      fill_pend <= 1'b0;
      fill_used <= '0;
    end else if (state == ST_FILL) begin
      fill_pend <= mem_re;
      if (mem_re) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (fill_count_en) begin
        fill_used <= fill_used + 1'b1;
      end
      div_num <= NUM_W'(fill_used) * NUM_W'(PERMILLE_SCALE);
    end else if (state == ST_DIV) begin
      div_prod <= PROD_W'(div_num) * PROD_W'(RECIP_M);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= res_data;
    end
  end

  `HETR_ASSERT_NOW(a_write_src, clk, rst, mem_we, (state == ST_CLEAR) || (state == ST_EXEC), "slot write outside clear or update")
  `HETR_ASSERT_NOW(a_fill_bound, clk, rst, state == ST_FILL, fill_used <= SAMPLE_W'(SAMPLE), "fill count beyond sample")
  `HETR_ASSERT_NEXT(a_accept_busy, clk, rst, in_xfer, state != ST_IDLE, "transfer accepted but block still idle")
  `HETR_ASSERT_NOW(a_load_free, clk, rst, load_out, !m_tvalid || m_tready, "result overwrites a pending transfer")

endmodule

`default_nettype wire

/* verif/hashed_entry_table_with_replacement_tb.sv */
`timescale 1ns / 1ps

module hashed_entry_table_with_replacement_tb;
  import het_pkg::*;

  localparam int INDEX_BITS  = 16;
  localparam int FILL_SAMPLE = 1000;
  localparam int SLOTS       = 1 << INDEX_BITS;
  localparam int FILL_SLOTS  = (FILL_SAMPLE < SLOTS) ? FILL_SAMPLE : SLOTS;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 321;
  localparam int KEY_POOL    = 32;
  localparam int STALL_LIMIT = 300000;
  localparam int END_QUIET   = FILL_SAMPLE + INDEX_BITS + 200;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [15:0]        eval;
    logic signed [10:0] depth;
    logic [1:0]         bound;
    logic [15:0]        move;
    logic [7:0]         ply;
    logic               after_drain;
  } table_req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic [9:0]  permille;
  } table_rsp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [14:0]  cfg_data = '0;

  hashed_entry_table_with_replacement #(
    .INDEX_BITS (INDEX_BITS),
    .FILL_SAMPLE(FILL_SAMPLE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  logic [63:0] tbl_key   [SLOTS];
  entry_t      tbl_entry [SLOTS];
  logic [5:0]  cfg_gen = '0;
  logic [14:0] cfg_thr = MATE_THRESHOLD_RESET;

  table_req_t item_queue[$];
  table_rsp_t pending_results[$];
  table_req_t cur_req;
  logic [63:0] key_pool [KEY_POOL];

  int send_idle_pct = 27;
  int recv_idle_pct = 87;
  int n_accepted = 0;
  int n_results = 0;
  int stall_cycles = 0;
  int error_count = 0;
  int n_reg_writes = 0;
  int n_probes = 0;
  int n_hits = 0;
  int n_stores = 0;
  int n_replaced = 0;
  int n_fills = 0;
  int n_unused = 0;

  task automatic table_access(input table_req_t rq, output table_rsp_t rs);
    int unsigned idx;
    entry_t      cur;
    entry_t      upd;
    logic        same;
    logic [15:0] mv;
    int          sc;
    int          adj;
    int          dp;
    int          cd;
    int          bonus;
    int          thr;
    int          ply;
    int          used;
    rs  = '0;
    idx = 32'(rq.key[INDEX_BITS-1:0]);
    cur = tbl_entry[idx];
    case (rq.mode)
      MODE_PROBE: begin
        n_probes++;
        if (tbl_key[idx] == rq.key && cur != '0 && cur.bound != BOUND_ABSENT) begin
          n_hits++;
          rs.hit   = 1'b1;
          rs.move  = cur.move;
          rs.score = cur.score;
          rs.eval  = cur.eval;
          rs.depth = cur.depth;
          rs.bound = cur.bound;
        end
      end
      MODE_STORE: begin
        n_stores++;
        sc    = int'($signed(rq.score));
        dp    = int'($signed(rq.depth));
        cd    = int'($signed(cur.depth));
        ply   = int'(rq.ply);
        thr   = int'(cfg_thr);
        bonus = (rq.bound == BOUND_BOTH) ? int'(EXACT_BONUS) : 0;
        same  = (cur != '0) && (tbl_key[idx] == rq.key);
        mv    = (same && rq.move == '0) ? cur.move : rq.move;
        if (cur == '0 || cur.bound == BOUND_ABSENT || same || cur.gen != cfg_gen ||
            dp + bonus >= cd) begin
          n_replaced++;
          adj = sc;
          if (sc >= thr) begin
            adj = sc + ply;
          end else if (sc <= -thr) begin
            adj = sc - ply;
          end
          if (adj > int'(SCORE_MAX)) adj = int'(SCORE_MAX);
          if (adj < int'(SCORE_MIN)) adj = int'(SCORE_MIN);
          if (dp > int'(DEPTH_MAX)) dp = int'(DEPTH_MAX);
          if (dp < int'(DEPTH_MIN)) dp = int'(DEPTH_MIN);
          upd.move  = mv;
          upd.score = adj[15:0];
          upd.eval  = rq.eval;
          upd.depth = dp[7:0];
          upd.bound = rq.bound;
          upd.gen   = cfg_gen;
          tbl_key[idx]   = rq.key;
          tbl_entry[idx] = upd;
        end
      end
      MODE_FILL: begin
        n_fills++;
        used = 0;
        for (int i = 0; i < FILL_SLOTS; i++) begin
          if (tbl_entry[i] != '0 && tbl_entry[i].gen == cfg_gen) used++;
        end
        rs.permille = 10'((used * PERMILLE_SCALE) / FILL_SLOTS);
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] expv,
                               input logic [15:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : drive
    logic       took;
    logic       busy;
    logic       next_valid;
    table_rsp_t rsp;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        table_access(cur_req, rsp);
        pending_results.push_back(rsp);
        n_accepted <= n_accepted + 1;
      end
      next_valid = s_tvalid && !s_tready;
      if (!next_valid && item_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        busy = took || (n_results < n_accepted);
        if (!(item_queue[0].after_drain && busy)) begin
          cur_req = item_queue.pop_front();
          s_tdata <= {3'b000, cur_req.ply, cur_req.move, cur_req.bound, cur_req.depth,
                      cur_req.eval, cur_req.score, cur_req.key};
          s_tuser <= cur_req.mode;
          next_valid = 1'b1;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  always @(posedge clk) begin : observe
    table_rsp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results <= n_results + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("hit", 16'(want.hit), 16'(m_tdata[0]));
          compare_field("found_move", want.move, m_tdata[16:1]);
          compare_field("found_score", want.score, m_tdata[32:17]);
          compare_field("found_eval", want.eval, m_tdata[48:33]);
          compare_field("found_depth", 16'(want.depth), 16'(m_tdata[56:49]));
          compare_field("found_bound", 16'(want.bound), 16'(m_tdata[58:57]));
          compare_field("fill_permille", 16'(want.permille), 16'(m_tdata[68:59]));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      n_reg_writes <= n_reg_writes + 1;
      case (cfg_index)
        REG_SEARCH_GENERATION: cfg_gen <= cfg_data[5:0];
        REG_MATE_THRESHOLD:    cfg_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic table_req_t req(input logic [1:0] mode, input logic [63:0] key,
                                     input int score, input int eval, input int depth,
                                     input logic [1:0] bound, input int move, input int ply);
    table_req_t rq;
    rq.mode        = mode;
    rq.key         = key;
    rq.score       = score[15:0];
    rq.eval        = eval[15:0];
    rq.depth       = depth[10:0];
    rq.bound       = bound;
    rq.move        = move[15:0];
    rq.ply         = ply[7:0];
    rq.after_drain = 1'b0;
    return rq;
  endfunction

  function automatic table_req_t random_req(input int thr);
    table_req_t rq;
    int         r;
    int         s;
    int         d;
    logic [63:0] wide;
    rq = '0;
    r = $urandom_range(99);
    rq.mode = (r < 45) ? MODE_PROBE : (r < 89) ? MODE_STORE : (r < 93) ? MODE_FILL : MODE_UNUSED;
    r = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (r < 10) begin
      rq.key = wide;
    end else if (r < 20) begin
      d = $urandom_range(FILL_SLOTS - 1);
      rq.key = {wide[63:16], d[15:0]};
    end else begin
      rq.key = key_pool[$urandom_range(KEY_POOL - 1)];
    end
    if ($urandom_range(99) < 30) begin
      s = thr + $urandom_range(2) - 1;
      if ($urandom_range(1) == 1) s = -s;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end else begin
      s = $urandom_range(65535);
    end
    rq.score = s[15:0];
    s = $urandom_range(65535);
    rq.eval = s[15:0];
    r = $urandom_range(99);
    if (r < 60) begin
      d = $urandom_range(14);
      d = d - 2;
    end else if (r < 80) begin
      d = $urandom_range(131, 126);
      if ($urandom_range(1) == 1) d = -d;
    end else begin
      d = $urandom_range(2047);
    end
    rq.depth = d[10:0];
    rq.bound = 2'($urandom_range(3));
    s = $urandom_range(65535);
    rq.move = ($urandom_range(3) == 0) ? 16'h0000 : s[15:0];
    rq.ply = 8'($urandom_range(255));
    rq.after_drain = ($urandom_range(199) == 0);
    return rq;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (item_queue.size() != 0 || s_tvalid || n_results < n_accepted) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int p);
    logic [5:0]  gen;
    logic [14:0] thr;
    table_req_t  rq;
    gen = 6'($urandom_range(63));
    thr = 15'($urandom_range(32767));
    case (p)
      0: begin gen = 6'd63; thr = 15'd32767; end
      1: begin gen = 6'd0;  thr = 15'd0;     end
      2: thr = MATE_THRESHOLD_RESET;
      3: gen = 6'd63;
      5: begin gen = 6'd0;  thr = 15'd32767; end
      default: ;
    endcase
    write_reg(REG_SEARCH_GENERATION, {9'd0, gen});
    write_reg(REG_MATE_THRESHOLD, thr);
    @(negedge clk);
    send_idle_pct = (p < 2) ? 27 : (p < 4) ? 87 : 0;
    recv_idle_pct = (p < 2) ? 87 : (p < 4) ? 27 : 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      rq = random_req(int'(thr));
      if (i == 100) rq.after_drain = 1'b1;
      item_queue.push_back(rq);
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int          slots [12] = '{0, 1, 2, 500, 998, 999, 1000, 1001, 4095, 32768, 65534, 65535};
    logic [63:0] wide;
    logic [47:0] hi;
    int          lo;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i]   = '0;
      tbl_entry[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) begin
      wide = {$urandom, $urandom};
      case ($urandom_range(3))
        0:       hi = '0;
        1:       hi = '1;
        default: hi = wide[63:16];
      endcase
      lo = (i < 24) ? slots[i % 12] : $urandom_range(FILL_SLOTS - 1);
      key_pool[i] = {hi, lo[15:0]};
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    item_queue.push_back(req(MODE_PROBE, 64'h0, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, 64'h0, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_PROBE, 64'h0, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, '1, 32767, -32768, 1023, BOUND_BOTH, 65535, 255));
    item_queue.push_back(req(MODE_PROBE, '1, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, '1, -32768, 32767, -1024, BOUND_UPPER, 0, 255));
    item_queue.push_back(req(MODE_PROBE, '1, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, 64'hFFFF, 100, 5, -200, BOUND_LOWER, 1, 0));
    item_queue.push_back(req(MODE_PROBE, 64'hFFFF, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_PROBE, '1, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, 64'hFFFF, 200, -5, -130, BOUND_BOTH, 2, 3));
    item_queue.push_back(req(MODE_PROBE, 64'hFFFF, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_PROBE, '1, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, 64'h1234_5678_9ABC_0005, 31743, 7, 50, BOUND_ABSENT,
                             16'h0101, 10));
    item_queue.push_back(req(MODE_PROBE, 64'h1234_5678_9ABC_0005, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, 64'h8000_0000_0000_0005, -31743, 9, -5, BOUND_UPPER,
                             16'h0202, 10));
    item_queue.push_back(req(MODE_PROBE, 64'h8000_0000_0000_0005, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_STORE, 64'h0F0F_0F0F_F0F0_000A, 31744, 11, 3, BOUND_LOWER,
                             16'h0303, 7));
    item_queue.push_back(req(MODE_STORE, 64'hF0F0_F0F0_0F0F_000B, -31744, 13, 0, BOUND_UPPER,
                             16'h0404, 7));
    item_queue.push_back(req(MODE_PROBE, 64'h0F0F_0F0F_F0F0_000A, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_PROBE, 64'hF0F0_F0F0_0F0F_000B, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_FILL, 64'h0, 0, 0, 0, BOUND_ABSENT, 0, 0));
    item_queue.push_back(req(MODE_UNUSED, 64'hA5A5_5A5A_C3C3_0005, -1, -1, -1, BOUND_BOTH,
                             65535, 255));
    item_queue.push_back(req(MODE_PROBE, 64'h8000_0000_0000_0005, 0, 0, 0, BOUND_ABSENT, 0, 0));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      run_phase(p);
    end

    wait_drained();
    repeat (END_QUIET) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Covered %0d probes (%0d hits), %0d stores (%0d written),", n_probes, n_hits,
             n_stores, n_replaced);
    $display("%0d fill estimates and %0d unused-mode items over %0d register writes",
             n_fills, n_unused, n_reg_writes);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/het_pkg.sv
rtl/hashed_entry_table_with_replacement.sv
verif/hashed_entry_table_with_replacement_tb.sv
